@@ rtl/bdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 16;
  localparam int unsigned EnW    = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegActiveLow = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDebounce  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDblWindow = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLongInit  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLongRep   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegEnable    = 3'd5;

  // bit positions inside event_enable
  localparam int unsigned EnRelease = 0;
  localparam int unsigned EnPress   = 1;
  localparam int unsigned EnDouble  = 2;
  localparam int unsigned EnLong    = 3;

  localparam logic [DelayW-1:0] DebounceRst  = 16'd20;
  localparam logic [DelayW-1:0] DblWindowRst = 16'd0;
  localparam logic [DelayW-1:0] LongInitRst  = 16'd1000;
  localparam logic [DelayW-1:0] LongRepRst   = 16'd500;

  typedef struct packed {
    logic              active_low;
    logic [DelayW-1:0] debounce_time;
    logic [DelayW-1:0] double_click_window;
    logic [DelayW-1:0] long_initial_delay;
    logic [DelayW-1:0] long_repeat_delay;
    logic [EnW-1:0]    event_enable;
  } cfg_t;

  typedef struct packed {
    logic long_press;
    logic double_click;
    logic press;
    logic release_ev;
  } evt_t;

endpackage

`default_nettype wire

@@ rtl/bdc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdc_cfg_regs
  import bdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [CfgIdxW-1:0] wr_index,
  input  wire logic [CfgDatW-1:0] wr_data,
  output cfg_t                    cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        RegActiveLow: cfg_nxt.active_low          = wr_data[0];
        RegDebounce:  cfg_nxt.debounce_time       = wr_data;
        RegDblWindow: cfg_nxt.double_click_window = wr_data;
        RegLongInit:  cfg_nxt.long_initial_delay  = wr_data;
        RegLongRep:   cfg_nxt.long_repeat_delay   = wr_data;
        RegEnable:    cfg_nxt.event_enable        = wr_data[EnW-1:0];
        default:      cfg_nxt = cfg_r; // drop writes beyond the map
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low          <= 1'b0;
      cfg_r.debounce_time       <= DebounceRst;
      cfg_r.double_click_window <= DblWindowRst;
      cfg_r.long_initial_delay  <= LongInitRst;
      cfg_r.long_repeat_delay   <= LongRepRst;
      cfg_r.event_enable        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/bdc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdc_core
  import bdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              pin_level,
  input  wire logic [TimeW-1:0]  now_ms,
  input  wire cfg_t              cfg,
  output evt_t                   evt
);

  logic             last_pressed_r, last_pressed_nxt;
  logic             stable_r, stable_nxt;
  logic [TimeW-1:0] deb_start_r, deb_start_nxt;
  logic [TimeW-1:0] press_time_r, press_time_nxt;
  logic [TimeW-1:0] long_mark_r, long_mark_nxt;
  logic             long_held_r, long_held_nxt;

  logic             pressed;
  logic             any_en;
  logic             settled;
  logic             press_edge, release_edge, holding;
  logic [TimeW-1:0] deb_age, press_age, long_age;

  assign pressed   = pin_level ^ cfg.active_low;
  assign any_en    = |cfg.event_enable;
  assign deb_age   = now_ms - deb_start_r;
  assign press_age = now_ms - press_time_r;
  assign long_age  = now_ms - long_mark_r;
  assign settled   = deb_age >= {{(TimeW-DelayW){1'b0}}, cfg.debounce_time};

  assign press_edge   = pressed  && !stable_r;
  assign release_edge = !pressed && stable_r;
  assign holding      = pressed  && stable_r;

  always_comb begin
    last_pressed_nxt = last_pressed_r;
    stable_nxt       = stable_r;
    deb_start_nxt    = deb_start_r;
    press_time_nxt   = press_time_r;
    long_mark_nxt    = long_mark_r;
    long_held_nxt    = long_held_r;
    evt              = '0;

    if (any_en) begin
      if (pressed != last_pressed_r) begin
        // level moved: restart the debounce timer
        last_pressed_nxt = pressed;
        deb_start_nxt    = now_ms;
      end else if (settled) begin
        evt.release_ev = cfg.event_enable[EnRelease] && release_edge;
        evt.press      = cfg.event_enable[EnPress] && press_edge;
        if (cfg.event_enable[EnDouble] && press_edge) begin
          if (press_age <= {{(TimeW-DelayW){1'b0}}, cfg.double_click_window}) begin
            evt.double_click = 1'b1;
          end else begin
            press_time_nxt = now_ms;
          end
        end
        if (cfg.event_enable[EnLong]) begin
          priority if (press_edge && !long_held_r) begin
            long_mark_nxt = now_ms;
          end else if (holding && !long_held_r &&
                       long_age >= {{(TimeW-DelayW){1'b0}}, cfg.long_initial_delay}) begin
            long_mark_nxt  = now_ms;
            long_held_nxt  = 1'b1;
            evt.long_press = 1'b1;
          end else if (holding && long_held_r &&
                       long_age >= {{(TimeW-DelayW){1'b0}}, cfg.long_repeat_delay}) begin
            long_mark_nxt  = now_ms;
            evt.long_press = 1'b1;
          end else if (release_edge && long_held_r) begin
            long_mark_nxt = now_ms;
            long_held_nxt = 1'b0;
          end else begin
            long_mark_nxt = long_mark_r;
          end
        end
        stable_nxt = pressed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pressed_r <= 1'b0;
      stable_r       <= 1'b0;
      deb_start_r    <= '0;
      press_time_r   <= '0;
      long_mark_r    <= '0;
      long_held_r    <= 1'b0;
    end else if (step) begin
      last_pressed_r <= last_pressed_nxt;
      stable_r       <= stable_nxt;
      deb_start_r    <= deb_start_nxt;
      press_time_r   <= press_time_nxt;
      long_mark_r    <= long_mark_nxt;
      long_held_r    <= long_held_nxt;
    end
  end

  // a long press can only be latched while the stable level is pressed
  a_held_needs_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(long_held_r) |-> stable_r)
    else $error("long press latched while released");

  // an event only fires once the level has settled
  a_evt_needs_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (|evt) |-> (settled && (pressed == last_pressed_r)))
    else $error("event raised on an unsettled level");

  // a release excludes both a press and a long press in the same beat
  a_edges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.press && evt.release_ev) && !(evt.long_press && evt.release_ev))
    else $error("conflicting events in one beat");

endmodule

`default_nettype wire

@@ rtl/button_debounce_click_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Button debouncer with press, release, double-click and long-press events.
// Each input beat carries one raw pin sample and its millisecond timestamp;
// exactly one result beat of four event flags comes back per sample. One
// sample is taken every clock cycle while the result side keeps taking beats:
// the sample register feeds a single pass of subtract-and-compare logic that
// updates the button state and loads the result register. Configuration
// writes are taken at any time but must only be issued while no samples are
// in flight.
module button_debounce_click_detector
  import bdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgDatW-1:0] cfg_data,
  // sample stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [39:0]        in_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
  // event stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata   // [0] release_event, [1] press_event,
                                              // [2] double_click_event,
                                              // [3] long_press_event, [7:4] zero
);

  cfg_t             cfg;
  evt_t             evt;

  logic             smp_valid_r, smp_valid_nxt;
  logic             smp_pin_r;
  logic [TimeW-1:0] smp_now_r;
  logic             out_valid_r, out_valid_nxt;
  evt_t             out_evt_r;
  logic             res_load;
  logic             in_fire;

  assign cfg_ready = 1'b1;

  bdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance the sample into the result register when that slot frees up
  assign res_load  = smp_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !smp_valid_r || res_load;
  assign in_fire   = in_tvalid && in_tready;

  bdc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (res_load),
    .pin_level (smp_pin_r),
    .now_ms    (smp_now_r),
    .cfg       (cfg),
    .evt       (evt)
  );

  always_comb begin
    smp_valid_nxt = smp_valid_r;
    if (in_fire) begin
      smp_valid_nxt = 1'b1;
    end else if (res_load) begin
      smp_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      smp_valid_r <= smp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_pin_r <= in_tdata[0];
      smp_now_r <= in_tdata[32:1];
    end
    if (res_load) begin
      out_evt_r <= evt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_evt_r.long_press, out_evt_r.double_click,
                       out_evt_r.press, out_evt_r.release_ev};

  // a held sample must not be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (smp_valid_r && !res_load) |-> !in_tready)
    else $error("sample register overrun");

  // a stalled result is not replaced
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !res_load)
    else $error("result replaced while stalled");

  // every accepted sample yields a result on the next free slot
  a_sample_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (smp_valid_r && (!out_valid_r || out_tready)) |=> out_valid_r)
    else $error("sample did not reach the result register");

  // the result register never shows press and release in the same beat
  a_out_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_evt_r.press && out_evt_r.release_ev))
    else $error("press and release reported together");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bdc_pkg::*;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned LongStall  = 300;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned PhaseItems = 122;
  localparam int unsigned NumPhases  = 8;

  // indexes past the register file: writes to these must be dropped
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef enum logic [1:0] {RxFlow, RxChoppy, RxSparse} rx_mode_t;

  class click_event_board;
    cfg_t             regs;
    logic             last_level;
    logic             stable_level;
    logic             long_active;
    logic [TimeW-1:0] settle_from;
    logic [TimeW-1:0] press_stamp;
    logic [TimeW-1:0] long_mark;
    evt_t             owed_events[$];
    int unsigned      faults;

    function new();
      regs.active_low          = 1'b0;
      regs.debounce_time       = DebounceRst;
      regs.double_click_window = DblWindowRst;
      regs.long_initial_delay  = LongInitRst;
      regs.long_repeat_delay   = LongRepRst;
      regs.event_enable        = '0;
      last_level   = 1'b0;
      stable_level = 1'b0;
      long_active  = 1'b0;
      settle_from  = '0;
      press_stamp  = '0;
      long_mark    = '0;
      faults       = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
      case (idx)
        RegActiveLow: regs.active_low          = val[0];
        RegDebounce:  regs.debounce_time       = val;
        RegDblWindow: regs.double_click_window = val;
        RegLongInit:  regs.long_initial_delay  = val;
        RegLongRep:   regs.long_repeat_delay   = val;
        RegEnable:    regs.event_enable        = val[EnW-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic pin, logic [TimeW-1:0] stamp);
      evt_t             ev;
      logic             lvl;
      logic             rising;
      logic             falling;
      logic             held;
      logic [TimeW-1:0] since;
      logic [TimeW-1:0] click_gap;
      logic [TimeW-1:0] hold_for;
      ev = '0;
      if (regs.event_enable != '0) begin
        lvl   = pin ^ regs.active_low;
        since = stamp - settle_from;
        if (lvl != last_level) begin
          last_level  = lvl;
          settle_from = stamp;
        end else if (since >= TimeW'(regs.debounce_time)) begin
          rising  = lvl && !stable_level;
          falling = !lvl && stable_level;
          held    = lvl && stable_level;
          ev.release_ev = regs.event_enable[EnRelease] && falling;
          ev.press      = regs.event_enable[EnPress] && rising;
          if (regs.event_enable[EnDouble] && rising) begin
            click_gap = stamp - press_stamp;
            // a double click leaves the recorded press where it was
            if (click_gap <= TimeW'(regs.double_click_window))
              ev.double_click = 1'b1;
            else
              press_stamp = stamp;
          end
          if (regs.event_enable[EnLong]) begin
            if (rising && !long_active)
              long_mark = stamp;
            hold_for = stamp - long_mark;
            if (held && !long_active && hold_for >= TimeW'(regs.long_initial_delay)) begin
              long_mark     = stamp;
              long_active   = 1'b1;
              ev.long_press = 1'b1;
            end else if (held && long_active &&
                         hold_for >= TimeW'(regs.long_repeat_delay)) begin
              long_mark     = stamp;
              ev.long_press = 1'b1;
            end else if (falling && long_active) begin
              long_mark   = stamp;
              long_active = 1'b0;
            end
          end
          stable_level = lvl;
        end
      end
      owed_events.push_back(ev);
    endfunction

    function void check_events(evt_t got);
      evt_t want;
      if (owed_events.size() == 0) begin
        faults++;
        if (faults <= MaxReports)
          $display("%0t: event beat %b with nothing owed", $time, got);
        return;
      end
      want = owed_events.pop_front();
      if (got.release_ev !== want.release_ev || got.press !== want.press ||
          got.double_click !== want.double_click || got.long_press !== want.long_press) begin
        faults++;
        if (faults <= MaxReports)
          $display("%0t: events {long,double,press,release} expected %b got %b",
                   $time, want, got);
      end
    endfunction

    function int unsigned pending();
      return owed_events.size();
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDatW-1:0]  cfg_data   = '0;
  logic                in_tvalid  = 1'b0;
  logic [39:0]         in_tdata   = '0;
  logic                out_tready = 1'b0;
  wire logic           cfg_ready;
  wire logic           in_tready;
  wire logic           out_tvalid;
  wire logic [7:0]     out_tdata;

  click_event_board board;
  bit               stall_request = 1'b0;
  int unsigned      quiet_cycles  = 0;
  int unsigned      hold_left     = 0;
  int unsigned      run_left      = 0;
  rx_mode_t         rx_mode       = RxFlow;
  int unsigned      burst_left    = 0;
  int unsigned      samples_sent  = 0;
  logic [TimeW-1:0] stamp_ms      = '0;
  logic             cur_active_low = 1'b0;

  always #10 clk = ~clk;

  button_debounce_click_detector u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // event side: long hold on request, otherwise runs of differing stall patterns
  always @(posedge clk) begin
    if (stall_request) begin
      stall_request = 1'b0;
      hold_left = LongStall;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 2));
        run_left = $urandom_range(4, 60);
      end
      run_left--;
      case (rx_mode)
        RxFlow:   out_tready <= 1'b1;
        RxChoppy: out_tready <= 1'($urandom);
        default:  out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_events(evt_t'(out_tdata[3:0]));
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // leaves cfg_valid high so that back-to-back writes need no second assignment
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  task automatic apply_setting(input logic al, input logic [DelayW-1:0] deb,
                               input logic [DelayW-1:0] win, input logic [DelayW-1:0] first,
                               input logic [DelayW-1:0] again, input logic [EnW-1:0] en);
    write_reg(RegActiveLow, {15'($urandom), al});
    write_reg(RegDebounce, deb);
    write_reg(RegDblWindow, win);
    write_reg(RegLongInit, first);
    write_reg(RegLongRep, again);
    write_reg(RegSpareLo, 16'($urandom));
    write_reg(RegEnable, {12'($urandom), en});
    write_reg(RegSpareHi, 16'($urandom));
    cfg_valid <= 1'b0;
    cur_active_low = al;
  endtask

  // leaves in_tvalid high; the next beat or an idle stretch decides what follows
  task automatic send_sample(input logic pin, input logic [TimeW-1:0] stamp);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, stamp, pin};
    do @(posedge clk); while (!in_tready);
    board.take_sample(pin, stamp);
  endtask

  task automatic idle_for(input int unsigned cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic emit(input logic pin, input int unsigned dt);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0)
        idle_for($urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    stamp_ms = stamp_ms + dt;
    send_sample(pin, stamp_ms);
    samples_sent++;
  endtask

  // bounce, hold down, bounce, hold up
  task automatic press_cycle(input int unsigned step);
    logic down_pin;
    down_pin = 1'b1 ^ cur_active_low;
    repeat ($urandom_range(0, 3)) emit(1'($urandom), $urandom_range(0, step / 4));
    repeat ($urandom_range(1, 10)) emit(down_pin, $urandom_range(0, step));
    repeat ($urandom_range(0, 3)) emit(1'($urandom), $urandom_range(0, step / 4));
    repeat ($urandom_range(1, 6)) emit(~down_pin, $urandom_range(0, step));
  endtask

  initial begin
    logic [DelayW-1:0] deb, win, first, again;
    logic [EnW-1:0]    en;
    logic              al;
    int unsigned       step;
    int unsigned       phase_end;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // everything disabled after reset: no events, no state change
    send_sample(1'b1, 32'h0000_0000);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'd100);
    send_sample(1'b1, 32'd200);
    drain();

    apply_setting(1'b0, 16'd4, 16'd60, 16'd30, 16'd10, 4'hF);
    send_sample(1'b1, 32'd1000);   // level change restarts the timer
    send_sample(1'b1, 32'd1002);   // not settled yet
    send_sample(1'b1, 32'd1004);   // press
    send_sample(1'b1, 32'd1020);
    send_sample(1'b1, 32'd1034);   // first long press
    send_sample(1'b1, 32'd1044);   // repeat
    send_sample(1'b0, 32'd1045);
    send_sample(1'b0, 32'd1050);   // release ends the long hold
    send_sample(1'b1, 32'd1052);
    send_sample(1'b1, 32'd1056);   // double click
    send_sample(1'b0, 32'd1060);
    send_sample(1'b0, 32'd1064);
    send_sample(1'b1, 32'd1070);
    send_sample(1'b1, 32'd1074);   // outside the window: plain press
    send_sample(1'b0, 32'd1075);
    send_sample(1'b0, 32'd1079);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      al    = 1'($urandom);
      deb   = DelayW'($urandom_range(0, 40));
      win   = DelayW'($urandom_range(0, 400));
      first = DelayW'($urandom_range(0, 300));
      again = DelayW'($urandom_range(0, 150));
      en    = ($urandom_range(0, 2) == 0) ? 4'hF : EnW'($urandom);
      case (ph)
        0: begin
          al = 1'b1; deb = '1; win = '1; first = '1; again = '1; en = 4'hF;
        end
        1: begin
          al = 1'b0; deb = '0; win = '0; first = '0; again = '0; en = 4'hF;
        end
        4: en = 4'b0111;
        default: ;
      endcase
      apply_setting(al, deb, win, first, again, en);
      step = deb;
      if (first > step) step = first;
      if (again > step) step = again;
      step = step / 3 + 2;
      stamp_ms = (ph == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
      if (ph == 3)
        stall_request = 1'b1;
      phase_end = samples_sent + PhaseItems;
      while (samples_sent < phase_end) begin
        if ($urandom_range(0, 9) < 8)
          press_cycle(step);
        else
          emit(1'($urandom), ($urandom_range(0, 19) == 0) ? $urandom
                                                          : $urandom_range(0, step));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
